[rtl/core/bmfc_pkg.sv]
// package for the binary majority filter (cross neighborhood)
// shared widths, reset values, the lane input struct and the result item struct
// no dependencies
`timescale 1ns / 1ps

package bmfc_pkg;

	// row word and config register widths
	localparam int ROW_W             = 64;
	localparam int CFG_W             = 7;
	localparam int DEFAULT_MAX_WIDTH = 64;

	// frame_width after reset
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET = 7'd64;

	// a pixel flips when more than this many neighbors agree
	localparam logic [2:0] MAJORITY_LIMIT = 3'd2;

	// neighborhood of one pixel, presence flags beside each neighbor bit
	typedef struct packed {
		logic has_up;
		logic up;
		logic has_down;
		logic down;
		logic has_left;
		logic left;
		logic has_right;
		logic right;
		logic mid;
		logic active;
	} lane_in_t;

	// one result item
	typedef struct packed {
		logic             last;
		logic [ROW_W-1:0] row;
	} out_item_t;

endpackage

[rtl/core/bmfc_lane.sv]
// one pixel lane of the majority filter: counts set and clear neighbors and decides
// depends on bmfc_pkg (lane_in_t, MAJORITY_LIMIT)
`timescale 1ns / 1ps

module bmfc_lane (
	input  bmfc_pkg::lane_in_t nbr,
	output logic               pix
);
	import bmfc_pkg::*;

	logic [2:0] set_cnt;
	logic [2:0] total_cnt;
	logic [2:0] clear_cnt;

	// count neighbors present and neighbors set
	assign total_cnt = 3'(nbr.has_up) + 3'(nbr.has_down) + 3'(nbr.has_left)
		+ 3'(nbr.has_right);
	assign set_cnt = 3'(nbr.has_up & nbr.up) + 3'(nbr.has_down & nbr.down)
		+ 3'(nbr.has_left & nbr.left) + 3'(nbr.has_right & nbr.right);
	assign clear_cnt = total_cnt - set_cnt;

	// an inactive lane gives zero; else clear majority wins first, then set majority, else keep the pixel
	always_comb begin
		if (!nbr.active) begin
			pix = 1'b0;
		end else if (clear_cnt > MAJORITY_LIMIT) begin
			pix = 1'b0;
		end else if (set_cnt > MAJORITY_LIMIT) begin
			pix = 1'b1;
		end else begin
			pix = nbr.mid;
		end
	end

endmodule

[rtl/core/bmfc_out_buf.sv]
// result stage: takes the merged lane bits as one item and holds it in a
// main register plus a skid register; depends on bmfc_pkg (out_item_t)
`timescale 1ns / 1ps

module bmfc_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  bmfc_pkg::out_item_t in_item,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output bmfc_pkg::out_item_t out_item
);
	import bmfc_pkg::*;

	logic      main_vld_q;
	logic      skid_vld_q;
	out_item_t main_q;
	out_item_t skid_q;

	// ready depends only on the skid register
	assign in_ready  = !skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_item  = main_q;

	// control: main drains or refills, skid catches an item during a stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_ready || !main_vld_q) begin
			if (skid_vld_q) begin
				main_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				main_vld_q <= in_valid;
			end
		end else if (in_valid && !skid_vld_q) begin
			skid_vld_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (out_ready || !main_vld_q) begin
			main_q <= skid_vld_q ? skid_q : in_item;
		end else if (in_valid && !skid_vld_q) begin
			skid_q <= in_item;
		end
	end

endmodule

[rtl/core/binary_majority_filter_cross.sv]
// binary majority filter, cross neighborhood: holds two rows, one lane per column
// a result is registered in the result stage when the item that completes it
// (the next row, or the end-of-frame item) is accepted
// throughput: one item per cycle; s_axis_tready drops only when both result
// registers are full; reset empties the held rows and sets frame_width to 64
`timescale 1ns / 1ps

module binary_majority_filter_cross #(
	parameter int MAX_WIDTH = bmfc_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// config register: frame_width
	input  logic                       cfg_wr_en,
	input  logic [bmfc_pkg::CFG_W-1:0] cfg_wr_data,
	// input items
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [bmfc_pkg::ROW_W-1:0] s_axis_tdata,  // [63:0] row_bits
	input  logic                       s_axis_tuser,  // [0] end_of_frame
	// result items
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [bmfc_pkg::ROW_W-1:0] m_axis_tdata,  // [63:0] filtered_row
	output logic                       m_axis_tlast   // last_row
);
	import bmfc_pkg::*;

	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_ONE  = 2'd1;
	localparam logic [1:0] HELD_TWO  = 2'd2;

	localparam logic [CFG_W-1:0] MAX_W = CFG_W'(MAX_WIDTH);
	localparam logic [ROW_W-1:0] LANE_MASK = (MAX_WIDTH >= ROW_W) ? {ROW_W{1'b1}}
		: ((ROW_W'(1) << MAX_WIDTH) - ROW_W'(1));

	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] width_eff;
	logic [ROW_W-1:0] row_above_q;
	logic [ROW_W-1:0] row_current_q;
	logic [1:0]       rows_held_q;
	logic             has_up;
	logic             s_fire;
	logic             push;
	logic [ROW_W-1:0] filt_row;
	out_item_t        res_item;
	out_item_t        m_item;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_WIDTH_RESET;
		end else if (cfg_wr_en) begin
			frame_width_q <= cfg_wr_data;
		end
	end

	// clamp width to 1..MAX_WIDTH
	always_comb begin
		if (frame_width_q == '0) begin
			width_eff = CFG_W'(1);
		end else if (frame_width_q > MAX_W) begin
			width_eff = MAX_W;
		end else begin
			width_eff = frame_width_q;
		end
	end

	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign has_up = (rows_held_q >= HELD_TWO);
	// any item with a row held gives a result
	assign push   = s_fire && (rows_held_q != HELD_NONE);

	// held rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_held_q   <= HELD_NONE;
			row_above_q   <= '0;
			row_current_q <= '0;
		end else if (s_fire) begin
			if (s_axis_tuser) begin
				rows_held_q   <= HELD_NONE;
				row_above_q   <= '0;
				row_current_q <= '0;
			end else if (rows_held_q == HELD_NONE) begin
				rows_held_q   <= HELD_ONE;
				row_current_q <= s_axis_tdata;
			end else begin
				rows_held_q   <= HELD_TWO;
				row_above_q   <= row_current_q;
				row_current_q <= s_axis_tdata;
			end
		end
	end

	// one lane per column; columns past MAX_WIDTH stay zero
	genvar j;
	generate
		for (j = 0; j < ROW_W; j++) begin : g_col
			if (j < MAX_WIDTH) begin : g_lane
				lane_in_t nbr;
				assign nbr.has_up   = has_up;
				assign nbr.up       = row_above_q[j];
				assign nbr.has_down = !s_axis_tuser;
				assign nbr.down     = s_axis_tdata[j];
				assign nbr.has_left = (j > 0);
				if (j > 0) begin : g_left
					assign nbr.left = row_current_q[j-1];
				end else begin : g_no_left
					assign nbr.left = 1'b0;
				end
				assign nbr.has_right = (CFG_W'(j + 1) < width_eff);
				if (j + 1 < ROW_W) begin : g_right
					assign nbr.right = row_current_q[j+1];
				end else begin : g_no_right
					assign nbr.right = 1'b0;
				end
				assign nbr.mid    = row_current_q[j];
				assign nbr.active = (CFG_W'(j) < width_eff);

				bmfc_lane u_lane (
					.nbr (nbr),
					.pix (filt_row[j])
				);
			end else begin : g_unused
				assign filt_row[j] = 1'b0;
			end
		end
	endgenerate

	// merge lane bits into the result item
	assign res_item.row  = filt_row;
	assign res_item.last = s_axis_tuser;

	bmfc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push),
		.in_item   (res_item),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (m_item)
	);

	assign m_axis_tdata = m_item.row;
	assign m_axis_tlast = m_item.last;

	// end of frame empties the held rows
	a_eof_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_axis_tuser |=> rows_held_q == HELD_NONE)
		else $error("held rows not cleared after end of frame");

	// an item with a row held leaves a result valid on m_axis the next cycle
	a_result_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> m_axis_tvalid)
		else $error("result item lost");

	// no bits beyond the lanes in a result
	a_no_stray_bits: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata & ~LANE_MASK) == '0)
		else $error("result has bits beyond MAX_WIDTH");

endmodule

[dv/majority_row_checker.sv]
// checker for binary_majority_filter_cross: watches the config port and both streams,
// predicts each filtered row and compares it with what the block delivers
// depends on bmfc_pkg
`timescale 1ns / 1ps

module majority_row_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [bmfc_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic                       s_axis_tvalid,
	input  logic                       s_axis_tready,
	input  logic [bmfc_pkg::ROW_W-1:0] s_axis_tdata,   // [63:0] row_bits
	input  logic                       s_axis_tuser,   // [0] end_of_frame
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic [bmfc_pkg::ROW_W-1:0] m_axis_tdata,   // [63:0] filtered_row
	input  logic                       m_axis_tlast,   // last_row
	output int                         fail_count,
	output int                         rows_pending,
	output int                         rows_out,
	output int                         frames_closed
);
	import bmfc_pkg::*;

	// rows the block still owes, oldest first
	out_item_t expected_rows[$];

	// mirror of the block state
	logic [CFG_W-1:0] width_q;
	logic [ROW_W-1:0] above_q;
	logic [ROW_W-1:0] current_q;
	logic [1:0]       held_q;

	// one filtered row: 4-neighbor majority vote, neighbors from the raw rows
	function automatic logic [ROW_W-1:0] majority_row(input logic [ROW_W-1:0] up,
			input logic has_up, input logic [ROW_W-1:0] mid,
			input logic [ROW_W-1:0] down, input logic has_down, input logic [CFG_W-1:0] wcfg);
		int unsigned      w;
		int unsigned      set_n;
		int unsigned      total_n;
		logic [ROW_W-1:0] m;
		logic [ROW_W-1:0] res;
		// width clamps to 1..MAX
		if (wcfg == 0)
			w = 1;
		else if (wcfg > DEFAULT_MAX_WIDTH)
			w = DEFAULT_MAX_WIDTH;
		else
			w = 32'(wcfg);
		m = (w >= ROW_W) ? {ROW_W{1'b1}} : ((64'd1 << w) - 64'd1);
		up = up & m;
		mid = mid & m;
		down = down & m;
		res = '0;
		for (int j = 0; j < ROW_W; j++) begin
			if (j < w) begin
				set_n = 0;
				total_n = 0;
				if (has_up) begin
					total_n++;
					set_n += 32'(up[j]);
				end
				if (has_down) begin
					total_n++;
					set_n += 32'(down[j]);
				end
				if (j > 0) begin
					total_n++;
					set_n += 32'(mid[j-1]);
				end
				if (j + 1 < w) begin
					total_n++;
					set_n += 32'(mid[j+1]);
				end
				if (total_n - set_n > MAJORITY_LIMIT)
					res[j] = 1'b0;
				else if (set_n > MAJORITY_LIMIT)
					res[j] = 1'b1;
				else
					res[j] = mid[j];
			end
		end
		return res;
	endfunction

	// one line per mismatch, and count it
	task automatic report_mismatch(input string what, input logic [ROW_W-1:0] got,
			input logic [ROW_W-1:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t item;
		if (!arst_n) begin
			expected_rows.delete();
			width_q = FRAME_WIDTH_RESET;
			above_q = '0;
			current_q = '0;
			held_q = 2'd0;
			rows_pending = 0;
			fail_count = 0;
			rows_out = 0;
			frames_closed = 0;
		end else begin
			// compare a delivered row with the oldest one owed
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_rows.size() == 0) begin
					report_mismatch("row with none owed", m_axis_tdata, '0);
				end else begin
					want = expected_rows.pop_front();
					if (m_axis_tdata !== want.row)
						report_mismatch("filtered_row", m_axis_tdata, want.row);
					if (m_axis_tlast !== want.last)
						report_mismatch("last_row", {63'd0, m_axis_tlast}, {63'd0, want.last});
				end
				rows_out++;
				if (m_axis_tlast)
					frames_closed++;
			end
			// register write
			if (cfg_wr_en)
				width_q = cfg_wr_data;
			// accepted item: advance the row window
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser) begin
					if (held_q != 2'd0) begin
						item.last = 1'b1;
						item.row = majority_row(above_q, held_q >= 2'd2, current_q, '0, 1'b0,
							width_q);
						expected_rows.insert(expected_rows.size(), item);
						above_q = '0;
						current_q = '0;
						held_q = 2'd0;
					end
				end else if (held_q == 2'd0) begin
					current_q = s_axis_tdata;
					held_q = 2'd1;
				end else begin
					item.last = 1'b0;
					item.row = majority_row(above_q, held_q >= 2'd2, current_q, s_axis_tdata,
						1'b1, width_q);
					expected_rows.insert(expected_rows.size(), item);
					above_q = current_q;
					current_q = s_axis_tdata;
					held_q = 2'd2;
				end
			end
			rows_pending = expected_rows.size();
		end
	end

endmodule

[dv/tb.sv]
// testbench top for binary_majority_filter_cross: clock, reset, stimulus and verdict
// directed frames first, then random frames over many widths; checking in majority_row_checker
// depends on bmfc_pkg, binary_majority_filter_cross and majority_row_checker
`timescale 1ns / 1ps

module tb;
	import bmfc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 500;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [ROW_W-1:0] s_axis_tdata;   // [63:0] row_bits
	logic             s_axis_tuser;   // [0] end_of_frame
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [ROW_W-1:0] m_axis_tdata;   // [63:0] filtered_row
	logic             m_axis_tlast;   // last_row

	int fail_count;
	int rows_pending;
	int rows_out;
	int frames_closed;
	int items_sent = 0;
	int width_writes = 0;
	int cycle_count = 0;
	bit src_idle_en = 1'b0;
	bit snk_idle_en = 1'b0;

	binary_majority_filter_cross dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	majority_row_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.rows_pending  (rows_pending),
		.rows_out      (rows_out),
		.frames_closed (frames_closed)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb NOT OK");
			$finish;
		end
	end

	// receiver: ready with random stall bursts
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (snk_idle_en && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6) - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// send one item, with an optional gap burst ahead of it
	task automatic send_item(input logic [ROW_W-1:0] row, input logic eof);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= row;
		s_axis_tuser <= eof;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_row(input logic [ROW_W-1:0] row);
		send_item(row, 1'b0);
	endtask

	// end of frame carries random junk in the row field
	task automatic send_eof();
		send_item({$urandom, $urandom}, 1'b1);
	endtask

	// stop sending and let every owed row drain
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (rows_pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_width(input logic [CFG_W-1:0] w);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		width_writes++;
	endtask

	// rows of mixed density so that both vote outcomes and ties all occur
	function automatic logic [ROW_W-1:0] pick_row();
		logic [ROW_W-1:0] a;
		logic [ROW_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return a & b & {$urandom, $urandom};
			4, 5:    return a | b | {$urandom, $urandom};
			default: return a;
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_width();
		case ($urandom_range(0, 9))
			0:       return 7'd1;
			1:       return 7'd2;
			2:       return 7'd64;
			3:       return 7'd0;
			4:       return CFG_W'($urandom_range(65, 127));
			default: return CFG_W'($urandom_range(1, 64));
		endcase
	endfunction

	initial begin
		int n_frames;
		int n_rows;
		bit late;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// full width after reset: solid, checkerboard and random rows
		send_row('1);
		send_row('0);
		send_row(64'h5555_5555_5555_5555);
		send_row(64'hAAAA_AAAA_AAAA_AAAA);
		send_row({$urandom, $urandom});
		send_eof();
		// end of frame with nothing held
		send_eof();
		// single-row frame
		send_row(64'h8000_0000_0000_0001);
		send_eof();
		// one column: no left or right neighbors
		wait_idle();
		set_width(7'd1);
		send_row(64'd1);
		send_row('0);
		send_row('1);
		send_eof();
		// zero width acts as one
		wait_idle();
		set_width(7'd0);
		send_row('1);
		send_row(64'h2);
		send_eof();
		// width above the maximum, then narrowed with two rows still held
		wait_idle();
		set_width(7'h7F);
		send_row({$urandom, $urandom});
		send_row({$urandom, $urandom});
		wait_idle();
		set_width(7'd2);
		send_row({$urandom, $urandom});
		send_eof();
		wait_idle();
		set_width(7'd63);
		send_row({$urandom, $urandom});
		send_row({$urandom, $urandom});
		send_row({$urandom, $urandom});
		send_eof();

		// random phases: new width, then a few frames; the tail runs without idling
		while (items_sent < ITEM_TARGET) begin
			wait_idle();
			late = items_sent > ITEM_TARGET - 80;
			src_idle_en = !late && $urandom_range(0, 3) != 0;
			snk_idle_en = !late && $urandom_range(0, 3) != 0;
			set_width(pick_width());
			n_frames = $urandom_range(2, 6);
			repeat (n_frames) begin
				n_rows = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
				repeat (n_rows)
					send_row(pick_row());
				// now and then a frame stays open across the width change
				if ($urandom_range(0, 15) != 0)
					send_eof();
				if ($urandom_range(0, 19) == 0)
					send_eof();
			end
		end

		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		wait_idle();
		repeat (10) @(negedge clk);
		$display("%0d items sent under %0d width settings (0 to 127 included)",
			items_sent, width_writes);
		$display("%0d filtered rows checked, %0d of them closing a frame",
			rows_out, frames_closed);
		if (fail_count == 0 && rows_pending == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

[files.f]
rtl/core/bmfc_pkg.sv
rtl/core/bmfc_lane.sv
rtl/core/bmfc_out_buf.sv
rtl/core/binary_majority_filter_cross.sv
dv/majority_row_checker.sv
dv/tb.sv
